@@ sv/deq_pkg.sv @@
// Package for the double-ended queue: request and response payload types and
// the operation codes. No dependencies.
package deq_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_BACK  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_BACK   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] pop_value;
        logic               was_empty;
        logic               overflow;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

endpackage

@@ sv/deq_chan.sv @@
// Valid/ready channel interface carrying one payload of a given type.
// Used with the payload types of deq_pkg.
interface deq_chan #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/double_ended_queue.sv @@
// Double-ended queue on a ring memory with a front index and an entry count.
// Depends on deq_pkg and the deq_chan interface.
//
// Usage: each request on req carries an operation (push front, push back,
// pop front, pop back) and a value used by pushes. Every request produces
// exactly one response on rsp with the popped value, an empty flag, an
// overflow flag and the entry count after the operation.
// A pop on an empty queue returns zero with was_empty set; a push into a
// full queue is dropped with overflow set. Both leave the queue unchanged.
// The edge that accepts a request also performs its synchronous memory
// access into the read stage; the response register loads from the read
// stage once it is free and drives rsp. Throughput is one request per cycle
// while rsp.ready stays high, set by the single memory access each request
// makes in its acceptance cycle.
// After reset the queue is empty; memory contents are not cleared and are
// never read before being written. When the receiver holds rsp.ready low,
// the response register and the read stage fill up and req.ready falls;
// nothing is lost or reordered.
module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic   clk,
    input  logic   rst_n,
    deq_chan.sink   req,
    deq_chan.source rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [DATA_WIDTH-1:0] ring_mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_pop_reg;
    logic             s1_empty_reg;
    logic             s1_over_reg;
    logic [CNT_W-1:0] s1_count_reg;

    logic             out_valid_reg, out_valid_next;
    deq_pkg::rsp_t    out_payload_reg, out_payload_next;

    logic             accept;
    logic             out_free;
    logic             s1_advance;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [SUM_W-1:0] sum_tail;
    logic [SUM_W-1:0] sum_last;
    logic [IDX_W-1:0] back_tail;
    logic [IDX_W-1:0] back_last;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  op_pop;
    logic                  op_empty;
    logic                  op_over;
    logic [63:0]           push_wide;
    logic [63:0]           rd_wide;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign req.ready  = !s1_valid_reg || out_free;
    assign accept     = req.valid && req.ready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? IDX_W'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(DEPTH - 1)) ? '0 : front_reg + 1'b1;

    assign sum_tail  = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign sum_last  = sum_tail - 1'b1;
    assign back_tail = (sum_tail >= SUM_W'(DEPTH)) ? IDX_W'(sum_tail - SUM_W'(DEPTH))
                                                   : IDX_W'(sum_tail);
    assign back_last = (sum_last >= SUM_W'(DEPTH)) ? IDX_W'(sum_last - SUM_W'(DEPTH))
                                                   : IDX_W'(sum_last);

    assign push_wide = 64'(req.payload.push_value);
    assign wr_data   = push_wide[DATA_WIDTH-1:0];

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = front_dec;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        op_pop     = 1'b0;
        op_empty   = 1'b0;
        op_over    = 1'b0;
        if (accept)
        begin
            case (req.payload.kind)
                deq_pkg::KIND_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        op_over = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                deq_pkg::KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        op_over = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = back_tail;
                        count_next = count_reg + 1'b1;
                    end
                end
                deq_pkg::KIND_POP_FRONT:
                begin
                    if (empty)
                    begin
                        op_empty = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        op_pop     = 1'b1;
                        rd_addr    = front_reg;
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                deq_pkg::KIND_POP_BACK:
                begin
                    if (empty)
                    begin
                        op_empty = 1'b1;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        op_pop     = 1'b1;
                        rd_addr    = back_last;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    front_next = front_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign rd_wide = 64'(rd_data_reg);

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_payload_next = out_payload_reg;
        if (s1_advance)
        begin
            out_valid_next               = 1'b1;
            out_payload_next.pop_value   = s1_pop_reg ? rd_wide[deq_pkg::VALUE_W-1:0] : '0;
            out_payload_next.was_empty   = s1_empty_reg;
            out_payload_next.overflow    = s1_over_reg;
            out_payload_next.entry_count = (CNT_W >= deq_pkg::COUNT_W)
                ? deq_pkg::COUNT_W'(s1_count_reg)
                : deq_pkg::COUNT_W'(s1_count_reg);
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pop_reg   <= op_pop;
            s1_empty_reg <= op_empty;
            s1_over_reg  <= op_over;
            s1_count_reg <= count_next;
        end
        out_payload_reg <= out_payload_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_payload_reg;

    // The entry count never exceeds the ring depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // A response never reports both an empty pop and a dropped push.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.payload.was_empty && rsp.payload.overflow))
        else $error("empty and overflow flags both set");

    // An empty pop returns zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.payload.was_empty |-> rsp.payload.pop_value == '0)
        else $error("empty pop returned nonzero value");

    // A push that is not dropped raises the count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && wr_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not advance the count");

    // A read stage holding a request blocks new requests while the output is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !rsp.ready |-> !req.ready)
        else $error("request accepted into a full pipeline");

endmodule

@@ tb/sv/double_ended_queue_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: random and directed push/pop requests
// checked against an in-bench ring model. Depends on deq_pkg, deq_chan and the DUT.

module double_ended_queue_test;

    localparam int QUEUE_DEPTH = 16;
    localparam int PHASE_REQUESTS = 540;
    localparam int DRAIN_CYCLES = 8;

    class deque_scoreboard;
        logic [deq_pkg::VALUE_W-1:0] ring [QUEUE_DEPTH];
        logic [3:0]                  front_idx;
        logic [deq_pkg::COUNT_W-1:0] held;
        deq_pkg::rsp_t               expected_q [$];
        int                          mismatches;
        int                          checked;
        int                          requests;
        int                          empties;
        int                          overflows;

        function new();
            front_idx = '0;
            held = '0;
            mismatches = 0;
            checked = 0;
            requests = 0;
            empties = 0;
            overflows = 0;
        endfunction

        function void note_request(deq_pkg::req_t r);
            deq_pkg::rsp_t e;
            logic [3:0]    slot;
            e = '0;
            requests++;
            if (r.kind == deq_pkg::KIND_PUSH_FRONT || r.kind == deq_pkg::KIND_PUSH_BACK)
            begin
                if (held == QUEUE_DEPTH)
                begin
                    e.overflow = 1'b1;
                end
                else
                begin
                    if (r.kind == deq_pkg::KIND_PUSH_FRONT)
                    begin
                        front_idx = front_idx - 4'd1;
                        slot = front_idx;
                    end
                    else
                    begin
                        slot = front_idx + held[3:0];
                    end
                    ring[slot] = r.push_value;
                    held = held + 5'd1;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    e.was_empty = 1'b1;
                end
                else
                begin
                    if (r.kind == deq_pkg::KIND_POP_FRONT)
                    begin
                        e.pop_value = ring[front_idx];
                        front_idx = front_idx + 4'd1;
                    end
                    else
                    begin
                        slot = front_idx + held[3:0] - 4'd1;
                        e.pop_value = ring[slot];
                    end
                    held = held - 5'd1;
                end
            end
            e.entry_count = held;
            expected_q.push_back(e);
        endfunction

        function void check_response(deq_pkg::rsp_t a);
            deq_pkg::rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("response with no request outstanding: pop_value %h count %0d",
                       a.pop_value, a.entry_count);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.was_empty) empties++;
            if (e.overflow) overflows++;
            if (a.pop_value !== e.pop_value)
            begin
                $error("pop_value: expected %h, got %h", e.pop_value, a.pop_value);
                mismatches++;
            end
            if (a.was_empty !== e.was_empty)
            begin
                $error("was_empty: expected %b, got %b", e.was_empty, a.was_empty);
                mismatches++;
            end
            if (a.overflow !== e.overflow)
            begin
                $error("overflow: expected %b, got %b", e.overflow, a.overflow);
                mismatches++;
            end
            if (a.entry_count !== e.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", e.entry_count, a.entry_count);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;

    deq_chan #(.payload_t(deq_pkg::req_t)) req_ch ();
    deq_chan #(.payload_t(deq_pkg::rsp_t)) rsp_ch ();

    deque_scoreboard sb = new();

    double_ended_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.payload);
            if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.payload);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #2_000_000;
        $display("double_ended_queue verification failed");
        $finish;
    end

    task automatic send_request(input deq_pkg::kind_t kind,
                                input logic [deq_pkg::VALUE_W-1:0] value);
        deq_pkg::req_t r;
        r.kind = kind;
        r.push_value = value;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    task automatic wait_for_drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic run_directed();
        int i;
        send_request(deq_pkg::KIND_POP_FRONT, 32'h1234_5678);
        send_request(deq_pkg::KIND_POP_BACK, '1);
        send_request(deq_pkg::KIND_PUSH_FRONT, '1);
        send_request(deq_pkg::KIND_PUSH_BACK, '0);
        send_request(deq_pkg::KIND_POP_BACK, '0);
        send_request(deq_pkg::KIND_POP_FRONT, '1);
        send_request(deq_pkg::KIND_POP_BACK, '0);
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin
            send_request((i % 2) ? deq_pkg::KIND_PUSH_BACK : deq_pkg::KIND_PUSH_FRONT,
                         (i % 3 == 0) ? ~(32'h1 << i) : (32'h1 << (31 - i)));
        end
        send_request(deq_pkg::KIND_PUSH_FRONT, 32'hDEAD_BEEF);
        send_request(deq_pkg::KIND_PUSH_BACK, 32'hCAFE_F00D);
    endtask

    task automatic run_random(input int count);
        int                          left;
        int                          burst;
        int                          push_pct;
        int                          i;
        deq_pkg::kind_t              kind;
        logic [deq_pkg::VALUE_W-1:0] value;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 40);
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 20;
                default: push_pct = 50;
            endcase
            for (i = 0; i < burst && left > 0; i++)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    kind = $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_BACK
                                                : deq_pkg::KIND_PUSH_FRONT;
                else
                    kind = $urandom_range(0, 1) ? deq_pkg::KIND_POP_BACK
                                                : deq_pkg::KIND_POP_FRONT;
                case ($urandom_range(0, 9))
                    0: value = '0;
                    1: value = '1;
                    default: value = $urandom;
                endcase
                send_request(kind, value);
                left--;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        send_idle_pct = 31;
        recv_idle_pct = 68;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(PHASE_REQUESTS);
        wait_for_drain();

        send_idle_pct = 68;
        recv_idle_pct = 31;
        run_random(PHASE_REQUESTS);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_REQUESTS);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests and checked %0d responses.", sb.requests, sb.checked);
        $display("Saw %0d empty pops and %0d dropped pushes under three pacing mixes.",
                 sb.empties, sb.overflows);
        if (sb.mismatches == 0)
            $display("double_ended_queue verification clean");
        else
            $display("double_ended_queue verification failed");
        $finish;
    end

endmodule
